// ===== rtl/lpvi_pkg.sv =====
// Shared types and codes for the log-pressure vertical interpolator.
// Used by lpvi_front, lpvi_back and the top level; depends on nothing.
package lpvi_pkg;

    localparam logic [1:0] KIND_LOAD_P = 2'd0;
    localparam logic [1:0] KIND_LOAD_V = 2'd1;
    localparam logic [1:0] KIND_QUERY  = 2'd2;

    localparam int IDX_W  = 5;
    localparam int PRES_W = 17;
    localparam int LN_W   = 21;
    localparam int VAL_W  = 32;
    localparam int QDEPTH = 2;

    typedef enum logic [1:0] {
        OP_LOAD_P,
        OP_LOAD_V,
        OP_QUERY
    } t_op;

    typedef struct packed {
        t_op                       op;
        logic [IDX_W-1:0]          idx;
        logic [PRES_W-1:0]         pres;
        logic [LN_W-1:0]           lnp;
        logic signed [VAL_W-1:0]   val;
    } t_item;

    typedef struct packed {
        logic  valid;
        t_item item;
    } t_qhs;

endpackage

// ===== rtl/lpvi_front.sv =====
// Front end: accepts input items, drops ignored ones, takes the log of the
// pressure and holds the work in a short queue. Depends on lpvi_pkg.
module lpvi_front #(
    parameter int MAX_LEVELS = 32
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        push,
    output logic                        full,
    input  logic [1:0]                  i_kind,
    input  logic [lpvi_pkg::IDX_W-1:0]  i_level_index,
    input  logic [lpvi_pkg::PRES_W-1:0] i_pressure,
    input  logic signed [lpvi_pkg::VAL_W-1:0] i_source_value,
    output lpvi_pkg::t_qhs              o_req,
    input  logic                        i_take
);
    import lpvi_pkg::*;

    localparam logic [15:0] LN_TAB [17] = '{
        16'd0, 16'd3973, 16'd7719, 16'd11262, 16'd14624, 16'd17821, 16'd20870,
        16'd23783, 16'd26573, 16'd29248, 16'd31818, 16'd34292, 16'd36675,
        16'd38975, 16'd41196, 16'd43345, 16'd45426
    };
    localparam logic [15:0] LN2_Q16 = 16'd45426;
    localparam int PW = $clog2(QDEPTH);
    localparam int CNTW = $clog2(QDEPTH + 1);

    // Table-based natural log, Q5.16.
    function automatic logic [LN_W-1:0] ln_q16(input logic [PRES_W-1:0] p);
        logic [4:0]  e;
        logic [32:0] sh;
        logic [15:0] f;
        logic [4:0]  k;
        logic [11:0] r;
        logic [15:0] lo;
        logic [15:0] hi;
        logic [23:0] prod;
        logic [23:0] acc;
        e = '0;
        for (int i = 1; i < PRES_W; i++) begin
            if (p[i]) e = 5'(i);
        end
        sh   = 33'(p) << (5'd16 - e);
        f    = sh[15:0];
        k    = {1'b0, f[15:12]};
        r    = f[11:0];
        lo   = LN_TAB[k];
        hi   = LN_TAB[k + 5'd1];
        prod = 24'(hi - lo) * 24'(r) + 24'd2048;
        acc  = 24'(e) * 24'(LN2_Q16) + 24'(lo) + 24'(prod[23:12]);
        if (p == '0) acc = '0;
        return acc[LN_W-1:0];
    endfunction

    t_item            r_mem [QDEPTH];
    logic [PW-1:0]    r_wp;
    logic [PW-1:0]    r_rp;
    logic [CNTW-1:0]  r_cnt;
    logic             keep;
    logic             enq;
    logic             deq;
    t_item            item;

    always_comb begin
        item.idx  = i_level_index;
        item.pres = i_pressure;
        item.lnp  = ln_q16(i_pressure);
        item.val  = i_source_value;
        item.op   = OP_QUERY;
        keep      = 1'b0;
        unique case (i_kind)
            KIND_LOAD_P: begin
                item.op = OP_LOAD_P;
                keep    = int'(i_level_index) < MAX_LEVELS;
            end
            KIND_LOAD_V: begin
                item.op = OP_LOAD_V;
                keep    = int'(i_level_index) < MAX_LEVELS;
            end
            KIND_QUERY: begin
                item.op = OP_QUERY;
                keep    = 1'b1;
            end
            default: keep = 1'b0;
        endcase
    end

    assign full        = r_cnt == CNTW'(QDEPTH);
    assign enq         = push && !full && keep;
    assign deq         = o_req.valid && i_take;
    assign o_req.valid = r_cnt != '0;
    assign o_req.item  = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (enq) r_mem[r_wp] <= item;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (enq) r_wp <= r_wp + PW'(1);
            if (deq) r_rp <= r_rp + PW'(1);
            r_cnt <= r_cnt + CNTW'(enq) - CNTW'(deq);
        end
    end

endmodule

// ===== rtl/lpvi_back.sv =====
// Back end: level tables, bracket search, product, serial divider and the
// result register. Depends on lpvi_pkg.
module lpvi_back #(
    parameter int MAX_LEVELS = 32
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic [$clog2(MAX_LEVELS+1)-1:0]       i_n_levels,
    input  lpvi_pkg::t_qhs                        i_req,
    output logic                                  o_take,
    output logic                                  empty,
    input  logic                                  pop,
    output logic [lpvi_pkg::IDX_W-1:0]            o_height_index,
    output logic signed [lpvi_pkg::VAL_W-1:0]     o_interpolated_value,
    output logic                                  o_degenerate
);
    import lpvi_pkg::*;

    localparam int AW  = $clog2(MAX_LEVELS);
    localparam int CW  = $clog2(MAX_LEVELS + 1);
    localparam int DLW = LN_W + 1;
    localparam int DVW = VAL_W + 1;
    localparam int PRW = DLW + DVW;
    localparam int RW  = PRW + 2;
    localparam int DCW = $clog2(PRW + 1);

    typedef enum logic [3:0] {
        S_IDLE, S_PRIME, S_SCAN, S_WA, S_GA, S_GB, S_MUL, S_PREP, S_DIV, S_FIN
    } t_state;

    logic [LN_W-1:0]          m_ln [MAX_LEVELS];
    logic [PRES_W-1:0]        m_pr [MAX_LEVELS];
    logic [VAL_W-1:0]         m_cv [MAX_LEVELS];
    logic [LN_W-1:0]          r_q_ln;
    logic [PRES_W-1:0]        r_q_pr;
    logic [VAL_W-1:0]         r_q_cv;

    t_state                   r_state;
    logic [AW-1:0]            r_addr;
    logic [AW-1:0]            r_k;
    logic [AW-1:0]            r_b;
    logic [PRES_W-1:0]        r_p;
    logic [LN_W-1:0]          r_lq;
    logic [LN_W-1:0]          r_la;
    logic [IDX_W-1:0]         r_hidx;
    logic signed [VAL_W-1:0]  r_va;
    logic signed [DLW-1:0]    r_dl;
    logic signed [DVW-1:0]    r_dv;
    logic signed [DLW-1:0]    r_den;
    logic signed [PRW-1:0]    r_prod;
    logic [PRW-1:0]           r_num;
    logic [DLW-1:0]           r_rem;
    logic [DLW-1:0]           r_dmag;
    logic                     r_neg;
    logic [DCW-1:0]           r_cnt;
    logic                     r_ovalid;
    logic [IDX_W-1:0]         r_oidx;
    logic signed [VAL_W-1:0]  r_oval;
    logic                     r_odeg;

    logic                     wr_lp;
    logic                     wr_cv;
    logic [AW-1:0]            wa;
    logic [DLW:0]             rem_sh;
    logic signed [RW-1:0]     q_s;
    logic signed [RW-1:0]     res;
    logic signed [VAL_W-1:0]  res_sat;

    assign o_take = r_state == S_IDLE;
    assign wa     = AW'(i_req.item.idx);
    assign wr_lp  = o_take && i_req.valid && i_req.item.op == OP_LOAD_P;
    assign wr_cv  = o_take && i_req.valid && i_req.item.op == OP_LOAD_V;

    always_ff @(posedge i_clk) begin
        if (wr_lp) begin
            m_ln[wa] <= i_req.item.lnp;
            m_pr[wa] <= i_req.item.pres;
        end
        if (wr_cv) m_cv[wa] <= i_req.item.val;
        r_q_ln <= m_ln[r_addr];
        r_q_pr <= m_pr[r_addr];
        r_q_cv <= m_cv[r_addr];
    end

    always_comb begin
        rem_sh = {r_rem, r_num[PRW-1]};
        q_s    = r_neg ? -$signed({2'b00, r_num}) : $signed({2'b00, r_num});
        res    = RW'(r_va) - q_s;
        if (r_den == '0) begin
            res_sat = r_va;
        end else if (res > RW'(signed'(32'sh7FFFFFFF))) begin
            res_sat = 32'sh7FFFFFFF;
        end else if (res < RW'(signed'(32'sh80000000))) begin
            res_sat = 32'sh80000000;
        end else begin
            res_sat = res[VAL_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_ovalid <= 1'b0;
        end else begin
            if (r_ovalid && pop) r_ovalid <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    if (i_req.valid && i_req.item.op == OP_QUERY) begin
                        r_p     <= i_req.item.pres;
                        r_lq    <= i_req.item.lnp;
                        r_hidx  <= i_req.item.idx;
                        r_addr  <= '0;
                        r_k     <= '0;
                        r_state <= S_PRIME;
                    end
                end
                S_PRIME: begin
                    r_addr  <= r_addr + AW'(1);
                    r_state <= S_SCAN;
                end
                S_SCAN: begin
                    if (r_q_pr <= r_p) begin
                        r_addr  <= r_k;
                        r_b     <= (r_k == '0) ? AW'(1) : r_k - AW'(1);
                        r_state <= S_WA;
                    end else if (CW'(r_k) == i_n_levels - CW'(1)) begin
                        r_addr  <= r_k;
                        r_b     <= r_k - AW'(1);
                        r_state <= S_WA;
                    end else begin
                        r_k    <= r_k + AW'(1);
                        r_addr <= r_addr + AW'(1);
                    end
                end
                S_WA: begin
                    r_addr  <= r_b;
                    r_state <= S_GA;
                end
                S_GA: begin
                    r_la    <= r_q_ln;
                    r_va    <= r_q_cv;
                    r_state <= S_GB;
                end
                S_GB: begin
                    r_dl    <= $signed({1'b0, r_la}) - $signed({1'b0, r_lq});
                    r_dv    <= DVW'(r_va) - DVW'($signed(r_q_cv));
                    r_den   <= $signed({1'b0, r_la}) - $signed({1'b0, r_q_ln});
                    r_state <= S_MUL;
                end
                S_MUL: begin
                    r_prod  <= r_dl * r_dv;
                    r_state <= S_PREP;
                end
                S_PREP: begin
                    r_num   <= r_prod[PRW-1] ? PRW'(-r_prod) : PRW'(r_prod);
                    r_dmag  <= r_den[DLW-1] ? DLW'(-r_den) : DLW'(r_den);
                    r_neg   <= r_prod[PRW-1] ^ r_den[DLW-1];
                    r_rem   <= '0;
                    r_cnt   <= DCW'(PRW);
                    r_state <= (r_den == '0) ? S_FIN : S_DIV;
                end
                S_DIV: begin
                    // One restoring step per cycle; quotient bits shift into r_num.
                    if (rem_sh >= {1'b0, r_dmag}) begin
                        r_rem <= DLW'(rem_sh - {1'b0, r_dmag});
                        r_num <= {r_num[PRW-2:0], 1'b1};
                    end else begin
                        r_rem <= rem_sh[DLW-1:0];
                        r_num <= {r_num[PRW-2:0], 1'b0};
                    end
                    r_cnt <= r_cnt - DCW'(1);
                    if (r_cnt == DCW'(1)) r_state <= S_FIN;
                end
                S_FIN: begin
                    if (!r_ovalid) begin
                        r_ovalid <= 1'b1;
                        r_oidx   <= r_hidx;
                        r_oval   <= res_sat;
                        r_odeg   <= r_den == '0;
                        r_state  <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign empty                = !r_ovalid;
    assign o_height_index       = r_oidx;
    assign o_interpolated_value = r_oval;
    assign o_degenerate         = r_odeg;

    a_div_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_DIV |-> r_dmag != '0)
        else $error("divider running with a zero divisor");
    a_scan_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_SCAN |-> CW'(r_k) < i_n_levels)
        else $error("bracket search ran past the levels in use");
    a_result_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_ovalid) |-> $past(r_state == S_FIN))
        else $error("result appeared outside the finish step");

endmodule

// ===== rtl/log_pressure_vertical_interp.sv =====
// Top level of the log-pressure vertical interpolator: configuration register,
// front end and back end. Depends on lpvi_pkg, lpvi_front and lpvi_back.
//
// Loads of a pressure level or source value are written into the level tables as
// the back end takes them. A query keeps the back end busy while the search reads
// one level per cycle from the level tables and a restoring divider produces the
// quotient, one of its 55 bits per cycle. When the pair's log pressures are equal
// the divider is skipped. A two-entry queue sits between the input and the back
// end, and one result register holds the finished value until it is popped.
module log_pressure_vertical_interp #(
    parameter int MAX_LEVELS = 32
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                push,
    output logic                                full,
    input  logic [1:0]                          i_kind,
    input  logic [lpvi_pkg::IDX_W-1:0]          i_level_index,
    input  logic [lpvi_pkg::PRES_W-1:0]         i_pressure,
    input  logic signed [lpvi_pkg::VAL_W-1:0]   i_source_value,
    output logic                                empty,
    input  logic                                pop,
    output logic [lpvi_pkg::IDX_W-1:0]          o_height_index,
    output logic signed [lpvi_pkg::VAL_W-1:0]   o_interpolated_value,
    output logic                                o_degenerate,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [4:0]                          i_cfg_data
);
    import lpvi_pkg::*;

    localparam int CW = $clog2(MAX_LEVELS + 1);

    logic [4:0]     r_cfg;
    logic [CW-1:0]  n_levels;
    t_qhs           req;
    logic           take;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= 5'd2;
        end else if (i_cfg_valid) begin
            r_cfg <= i_cfg_data;
        end
    end

    // The level count is clamped to at least two and at most the table depth.
    always_comb begin
        if (r_cfg < 5'd2) begin
            n_levels = CW'(2);
        end else if (int'(r_cfg) > MAX_LEVELS) begin
            n_levels = CW'(MAX_LEVELS);
        end else begin
            n_levels = CW'(r_cfg);
        end
    end

    lpvi_front #(.MAX_LEVELS(MAX_LEVELS)) u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .push           (push),
        .full           (full),
        .i_kind         (i_kind),
        .i_level_index  (i_level_index),
        .i_pressure     (i_pressure),
        .i_source_value (i_source_value),
        .o_req          (req),
        .i_take         (take)
    );

    lpvi_back #(.MAX_LEVELS(MAX_LEVELS)) u_back (
        .i_clk                (i_clk),
        .i_rst_n              (i_rst_n),
        .i_n_levels           (n_levels),
        .i_req                (req),
        .o_take               (take),
        .empty                (empty),
        .pop                  (pop),
        .o_height_index       (o_height_index),
        .o_interpolated_value (o_interpolated_value),
        .o_degenerate         (o_degenerate)
    );

endmodule

// ===== tb/log_pressure_vertical_interp_test.sv =====
// Self-checking testbench for log_pressure_vertical_interp: level tables, queries,
// level-count register, backpressure. Depends on lpvi_pkg and the RTL top level.
module log_pressure_vertical_interp_test;
    import lpvi_pkg::*;

    localparam logic [1:0] KIND_UNUSED = 2'd3;
    localparam int TABLE_DEPTH = 32;
    localparam int LN2_Q16 = 45426;
    localparam int DRAIN_CYCLES = 150;
    localparam int CYCLE_LIMIT = 1000000;
    localparam int HOLD_CYCLES = 400;

    typedef struct {
        logic [IDX_W-1:0]        height;
        logic signed [VAL_W-1:0] value;
        logic                    degen;
    } t_interp_result;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic push = 1'b0;
    logic full;
    logic [1:0] i_kind = KIND_LOAD_P;
    logic [IDX_W-1:0] i_level_index = '0;
    logic [PRES_W-1:0] i_pressure = '0;
    logic signed [VAL_W-1:0] i_source_value = '0;
    logic empty;
    logic pop = 1'b0;
    logic [IDX_W-1:0] o_height_index;
    logic signed [VAL_W-1:0] o_interpolated_value;
    logic o_degenerate;
    logic i_cfg_valid = 1'b0;
    logic o_cfg_ready;
    logic [4:0] i_cfg_data = '0;

    // Shadow copy of the block's tables and register.
    logic [PRES_W-1:0] level_pres [TABLE_DEPTH];
    logic [LN_W-1:0] level_ln [TABLE_DEPTH];
    logic signed [VAL_W-1:0] level_val [TABLE_DEPTH];
    logic [4:0] levels_in_use = 5'd2;

    t_interp_result pending_results[$];
    int mismatches = 0;
    int results_seen = 0;
    int queries_sent = 0;
    int degen_seen = 0;
    int cycles = 0;
    bit quiet_mode = 1'b0;
    bit hold_request = 1'b0;
    int recv_stall = 0;

    log_pressure_vertical_interp dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .push(push), .full(full),
        .i_kind(i_kind), .i_level_index(i_level_index),
        .i_pressure(i_pressure), .i_source_value(i_source_value),
        .empty(empty), .pop(pop),
        .o_height_index(o_height_index),
        .o_interpolated_value(o_interpolated_value),
        .o_degenerate(o_degenerate),
        .i_cfg_valid(i_cfg_valid), .o_cfg_ready(o_cfg_ready),
        .i_cfg_data(i_cfg_data)
    );

    always #6 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    function automatic logic [LN_W-1:0] ln_pressure(input logic [PRES_W-1:0] p);
        int unsigned e, f, k, r, lo, hi;
        int unsigned lut [17] = '{0, 3973, 7719, 11262, 14624, 17821, 20870, 23783,
            26573, 29248, 31818, 34292, 36675, 38975, 41196, 43345, 45426};
        if (p == 0) return '0;
        e = 0;
        while (e < 16 && (p >> (e + 1)) != 0) e++;
        f = ((32'(p) << (16 - e)) - 32'd65536) & 32'hFFFF;
        k = f >> 12;
        r = f & 32'hFFF;
        lo = lut[k];
        hi = lut[k + 1];
        return LN_W'(e * LN2_Q16 + lo + (((hi - lo) * r + 2048) >> 12));
    endfunction

    function automatic t_interp_result interpolate(input logic [IDX_W-1:0] height,
                                                   input logic [PRES_W-1:0] p);
        t_interp_result res;
        int n, k, a, b;
        longint la, lb, lq, va, vb, den, v;
        n = levels_in_use;
        if (n < 2) n = 2;
        k = 0;
        while (k < n && level_pres[k] > p) k++;
        if (k == n) begin
            a = n - 1; b = n - 2;
        end else if (k == 0) begin
            a = 0; b = 1;
        end else begin
            a = k; b = k - 1;
        end
        la = longint'(level_ln[a]);
        lb = longint'(level_ln[b]);
        lq = longint'(ln_pressure(p));
        va = longint'(level_val[a]);
        vb = longint'(level_val[b]);
        den = la - lb;
        res.height = height;
        res.degen = (den == 0);
        if (den == 0) begin
            v = va;
        end else begin
            v = va - ((la - lq) * (va - vb)) / den;
            if (v > 64'sd2147483647) v = 64'sd2147483647;
            if (v < -64'sd2147483648) v = -64'sd2147483648;
        end
        res.value = v[31:0];
        return res;
    endfunction

    // Receiver: random stall bursts, plus a long hold-off on request.
    always @(negedge i_clk) begin
        if (recv_stall > 0) begin
            recv_stall = recv_stall - 1;
        end else if (!quiet_mode && $urandom_range(0, 5) == 0) begin
            recv_stall = $urandom_range(1, 9);
        end
        pop = !hold_request && recv_stall == 0;
    end

    always @(posedge i_clk) begin
        if (i_rst_n && !empty && pop) begin
            t_interp_result exp_r;
            results_seen++;
            if (pending_results.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result: height %0d value %0d", o_height_index,
                             o_interpolated_value);
            end else begin
                exp_r = pending_results.pop_front();
                if (o_degenerate) degen_seen++;
                if (exp_r.height !== o_height_index || exp_r.value !== o_interpolated_value
                        || exp_r.degen !== o_degenerate) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("result mismatch: expected %0d/%0d/%0b got %0d/%0d/%0b",
                                 exp_r.height, exp_r.value, exp_r.degen,
                                 o_height_index, o_interpolated_value, o_degenerate);
                end
            end
        end
    end

    task automatic send_item(input logic [1:0] kind, input logic [IDX_W-1:0] idx,
                             input logic [PRES_W-1:0] p, input logic [VAL_W-1:0] v);
        int gap;
        gap = 0;
        if (!quiet_mode && $urandom_range(0, 6) == 0) gap = $urandom_range(1, 9);
        if (gap > 0) begin
            @(negedge i_clk) push = 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        push = 1'b1;
        i_kind = kind;
        i_level_index = idx;
        i_pressure = p;
        i_source_value = v;
        @(posedge i_clk);
        while (full) @(posedge i_clk);
        case (kind)
            KIND_LOAD_P: begin
                level_pres[idx] = p;
                level_ln[idx] = ln_pressure(p);
            end
            KIND_LOAD_V: level_val[idx] = v;
            KIND_QUERY: begin
                pending_results.push_back(interpolate(idx, p));
                queries_sent++;
            end
            default: ;
        endcase
    endtask

    // Lets the block drain completely, then writes the level count.
    task automatic set_level_count(input logic [4:0] count);
        @(negedge i_clk) push = 1'b0;
        wait (pending_results.size() == 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        i_cfg_valid = 1'b1;
        i_cfg_data = count;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        levels_in_use = count;
        @(negedge i_clk) i_cfg_valid = 1'b0;
    endtask

    // Loads a non-increasing pressure profile with random values on every level.
    task automatic load_profile(input bit allow_equal);
        int p;
        p = $urandom_range(90000, 131071);
        for (int i = 0; i < TABLE_DEPTH; i++) begin
            send_item(KIND_LOAD_P, IDX_W'(i), PRES_W'(p), $urandom);
            send_item(KIND_LOAD_V, IDX_W'(i), '0, $urandom);
            if (allow_equal && $urandom_range(0, 7) == 0) continue;
            p = p - $urandom_range(1, 5000);
            if (p < 1) p = 1;
        end
    endtask

    task automatic test_directed_basics();
        load_profile(1'b0);
        send_item(KIND_QUERY, 0, 17'h1FFFF, 0);
        send_item(KIND_QUERY, 31, 1, 0);
        send_item(KIND_QUERY, 5, 0, 0);
        send_item(KIND_QUERY, 7, level_pres[1], 0);
        send_item(KIND_UNUSED, 31, 17'h1FFFF, 32'hFFFF_FFFF);
        send_item(KIND_LOAD_V, 0, 0, 32'h7FFF_FFFF);
        send_item(KIND_LOAD_V, 1, 0, 32'h8000_0000);
        send_item(KIND_QUERY, 3, 1, 0);
        send_item(KIND_QUERY, 4, 17'h1FFFF, 0);
        // Equal pressures on the bracketing pair.
        send_item(KIND_LOAD_P, 1, level_pres[0], 0);
        send_item(KIND_QUERY, 9, 50000, 0);
    endtask

    task automatic test_level_extremes();
        logic [4:0] counts [5] = '{5'd0, 5'd1, 5'd31, 5'd2, 5'd16};
        foreach (counts[c]) begin
            set_level_count(counts[c]);
            send_item(KIND_QUERY, IDX_W'(c), 17'h1FFFF, 0);
            send_item(KIND_QUERY, IDX_W'(c + 8), 1, 0);
            send_item(KIND_QUERY, IDX_W'(c + 16), PRES_W'($urandom_range(1, 131071)), 0);
        end
    endtask

    task automatic test_backpressure();
        hold_request = 1'b1;
        fork
            begin
                repeat (HOLD_CYCLES) @(posedge i_clk);
                hold_request = 1'b0;
            end
        join_none
        repeat (12)
            send_item(KIND_QUERY, IDX_W'($urandom), PRES_W'($urandom_range(1, 131071)), 0);
    endtask

    task automatic test_random_phases(input int item_count);
        int sent;
        int r;
        sent = 0;
        while (sent < item_count) begin
            if ($urandom_range(0, 3) == 0) set_level_count(5'($urandom));
            if ($urandom_range(0, 2) == 0) begin
                load_profile(1'($urandom_range(0, 1)));
                sent += 2 * TABLE_DEPTH;
            end
            repeat ($urandom_range(10, 40)) begin
                r = $urandom_range(0, 19);
                if (r < 15)
                    send_item(KIND_QUERY, IDX_W'($urandom),
                              PRES_W'($urandom_range(1, 131071)), 0);
                else if (r < 17)
                    send_item(KIND_LOAD_P, IDX_W'($urandom), PRES_W'($urandom), 0);
                else if (r < 19)
                    send_item(KIND_LOAD_V, IDX_W'($urandom), '0, $urandom);
                else
                    send_item(KIND_UNUSED, IDX_W'($urandom), PRES_W'($urandom), $urandom);
                sent++;
            end
        end
    endtask

    initial begin
        repeat (6) @(posedge i_clk);
        @(negedge i_clk) i_rst_n = 1'b1;
        test_directed_basics();
        test_level_extremes();
        test_backpressure();
        test_random_phases(1500);
        quiet_mode = 1'b1;
        test_random_phases(250);
        @(negedge i_clk) push = 1'b0;
        wait (pending_results.size() == 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        $display("Ran %0d queries, checked %0d results (%0d with equal pair log pressures).",
                 queries_sent, results_seen, degen_seen);
        $display("Level counts included the clamped extremes; %0d mismatches.", mismatches);
        if (mismatches == 0 && pending_results.size() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
